FILE: design/tapf_pkg.sv
// Shared types and constants of the two-anchor position fix.
`timescale 1ns / 1ps
package tapf_pkg;

    localparam int CFG_W   = 16;  // width of both configuration registers
    localparam int XQ_W    = 32;  // quotient bits kept for x before saturation
    localparam int XE_QW   = 26;  // quotient bits kept for the x error term
    localparam int VAR_QW  = 24;  // quotient bits kept ahead of a variance square
    localparam int VAR_W   = 48;  // variance width
    localparam int XE2_W   = 2 * XE_QW;
    localparam int MAG_W   = 54;  // y error numerator magnitude
    localparam int POSX_W  = 32;
    localparam int POSY_W  = 16;

    localparam logic [POSX_W-1:0] POSX_MAX = 32'h7FFF_FFFF;
    localparam logic [POSX_W-1:0] POSX_MIN = 32'h8000_0000;

    // register map: index is paddr[2]
    localparam logic REG_BASELINE = 1'b0;
    localparam logic REG_ERROR    = 1'b1;

    localparam logic [CFG_W-1:0] BASELINE_RST = 16'd1000;
    localparam logic [CFG_W-1:0] ERROR_RST    = 16'd100;

    typedef enum logic [1:0] {
        ST_VALID  = 2'd0,
        ST_NOMEET = 2'd1,
        ST_YZERO  = 2'd2
    } t_fix_status;

endpackage

FILE: design/two_anchor_position_fix.sv
// Two-anchor position fix: pipelined circle intersection with error variances.
//
// Usage: pulse i_start with a range pair on i_range_far / i_range_near; o_busy
// stays low, so a new word is taken on every clock edge where i_start is high.
// Each word produces exactly one result word on o_pos_x, o_pos_y, o_var_x,
// o_var_y and o_fix_status, marked by o_done for one cycle. Throughput is
// one word per cycle. The pipeline holds three bit-serial chains laid out
// in space: a 32-stage divider for x (in parallel with a 26-stage divider
// for the x error), a RANGE_BITS-stage square root, and a 24-stage
// divider for the y error.
// The receiver cannot stall, so nothing in the pipeline ever holds.
// Reset (synchronous, i_rst_n low) empties the pipeline and loads the
// baseline register with 1000 and the range error register with 100.
// The APB port writes the registers at byte 0 (baseline) and 4 (range error);
// change them only while no word is in flight, since stages read them live.
`timescale 1ns / 1ps
module two_anchor_position_fix
    import tapf_pkg::*;
#(
    parameter int RANGE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [RANGE_BITS-1:0]    i_range_far,
    input  logic [RANGE_BITS-1:0]    i_range_near,
    output logic                     o_done,
    output logic [POSX_W-1:0]        o_pos_x,
    output logic [POSY_W-1:0]        o_pos_y,
    output logic [VAR_W-1:0]         o_var_x,
    output logic [VAR_W-1:0]         o_var_y,
    output logic [1:0]               o_fix_status,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int RB   = RANGE_BITS;
    localparam int SQW  = 2 * RB;                            // range squared
    localparam int NW   = ((SQW > 32) ? SQW : 32) + 1;       // x numerator magnitude
    localparam int SW   = ((RB > CFG_W) ? RB : CFG_W) + 2;   // d0 + d1 + e
    localparam int XNW  = CFG_W + SW;                        // x error numerator
    localparam int DX_W = CFG_W + 1;                         // 2b
    localparam int YDW  = RB + 1;                            // 2y
    localparam int CR_W = RB + XE_QW;                        // ax * xerr
    localparam int DE_W = RB + CFG_W;                        // d1 * e

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_base;
    logic [CFG_W-1:0] r_err;
    logic             cfg_wr;
    logic [CFG_W-1:0] b_eff;
    logic [DX_W-1:0]  dx;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASELINE_RST;
            r_err  <= ERROR_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_BASELINE: r_base <= pwdata[CFG_W-1:0];
                REG_ERROR:    r_err  <= pwdata[CFG_W-1:0];
                default:      r_base <= r_base;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_ERROR) ? 32'(r_err) : 32'(r_base);

    // A zero baseline is out of range; treat it as one millimetre.
    assign b_eff = (r_base == '0) ? CFG_W'(1) : r_base;
    assign dx    = {b_eff, 1'b0};

    // Every stage advances every cycle.
    assign o_busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: squares and the error sum
    // ------------------------------------------------------------------
    logic            r_s1_v;
    logic [RB-1:0]   r_s1_d1;
    logic [SQW-1:0]  r_s1_d0sq, r_s1_d1sq;
    logic [31:0]     r_s1_bsq;
    logic [SW-1:0]   r_s1_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_v <= 1'b0;
        else          r_s1_v <= i_start;
        r_s1_d1   <= i_range_near;
        r_s1_d0sq <= SQW'(i_range_far) * SQW'(i_range_far);
        r_s1_d1sq <= SQW'(i_range_near) * SQW'(i_range_near);
        r_s1_bsq  <= 32'(b_eff) * 32'(b_eff);
        r_s1_sum  <= SW'(i_range_far) + SW'(i_range_near) + SW'(r_err);
    end

    // ------------------------------------------------------------------
    // Stage 2: collect the negative terms of the x numerator, form e*sum
    // ------------------------------------------------------------------
    logic            r_s2_v;
    logic [RB-1:0]   r_s2_d1;
    logic [SQW-1:0]  r_s2_d1sq;
    logic [NW-1:0]   r_s2_p, r_s2_n;
    logic [XNW-1:0]  r_s2_xen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_v <= 1'b0;
        else          r_s2_v <= r_s1_v;
        r_s2_d1   <= r_s1_d1;
        r_s2_d1sq <= r_s1_d1sq;
        r_s2_p    <= NW'(r_s1_d0sq);
        r_s2_n    <= NW'(r_s1_d1sq) + NW'(r_s1_bsq);
        r_s2_xen  <= XNW'(r_err) * XNW'(r_s1_sum);
    end

    // ------------------------------------------------------------------
    // Stage 3: sign and magnitude of the x numerator
    // ------------------------------------------------------------------
    logic            r_s3_v;
    logic            r_s3_neg;
    logic [RB-1:0]   r_s3_d1;
    logic [SQW-1:0]  r_s3_d1sq;
    logic [NW-1:0]   r_s3_mag;
    logic [XNW-1:0]  r_s3_xen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3_v <= 1'b0;
        else          r_s3_v <= r_s2_v;
        r_s3_neg  <= r_s2_n > r_s2_p;
        r_s3_mag  <= (r_s2_n > r_s2_p) ? (r_s2_n - r_s2_p) : (r_s2_p - r_s2_n);
        r_s3_d1   <= r_s2_d1;
        r_s3_d1sq <= r_s2_d1sq;
        r_s3_xen  <= r_s2_xen;
    end

    // ------------------------------------------------------------------
    // x and x-error dividers, one quotient bit per stage.
    // A quotient that cannot fit its kept bits is flagged up front, which
    // also guarantees the starting remainder is below the divisor.
    // ------------------------------------------------------------------
    logic             r_dv_v     [0:XQ_W];
    logic             r_dv_neg   [0:XQ_W];
    logic             r_dv_ovfx  [0:XQ_W];
    logic             r_dv_ovfe  [0:XQ_W];
    logic [RB-1:0]    r_dv_d1    [0:XQ_W];
    logic [SQW-1:0]   r_dv_d1sq  [0:XQ_W];
    logic [DX_W-1:0]  r_xrem     [0:XQ_W];
    logic [XQ_W-1:0]  r_xlo      [0:XQ_W];
    logic [XQ_W-1:0]  r_xq       [0:XQ_W];
    logic [CFG_W-1:0] r_erem     [0:XQ_W];
    logic [XE_QW-1:0] r_elo      [0:XQ_W];
    logic [XE_QW-1:0] r_eq       [0:XQ_W];

    logic ovfx_in, ovfe_in;
    assign ovfx_in = 64'(r_s3_mag >> XQ_W) >= 64'(dx);
    assign ovfe_in = 64'(r_s3_xen >> XE_QW) >= 64'(b_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv_v[0] <= 1'b0;
        else          r_dv_v[0] <= r_s3_v;
        r_dv_neg[0]  <= r_s3_neg;
        r_dv_ovfx[0] <= ovfx_in;
        r_dv_ovfe[0] <= ovfe_in;
        r_dv_d1[0]   <= r_s3_d1;
        r_dv_d1sq[0] <= r_s3_d1sq;
        r_xrem[0]    <= ovfx_in ? '0 : DX_W'(r_s3_mag >> XQ_W);
        r_xlo[0]     <= r_s3_mag[XQ_W-1:0];
        r_xq[0]      <= '0;
        r_erem[0]    <= ovfe_in ? '0 : CFG_W'(r_s3_xen >> XE_QW);
        r_elo[0]     <= r_s3_xen[XE_QW-1:0];
        r_eq[0]      <= '0;
    end

    for (genvar k = 0; k < XQ_W; k++) begin : g_xdiv
        logic [DX_W:0] xt;
        logic          xge;
        assign xt  = {r_xrem[k], r_xlo[k][XQ_W-1]};
        assign xge = xt >= {1'b0, dx};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv_v[k+1] <= 1'b0;
            else          r_dv_v[k+1] <= r_dv_v[k];
            r_dv_neg[k+1]  <= r_dv_neg[k];
            r_dv_ovfx[k+1] <= r_dv_ovfx[k];
            r_dv_ovfe[k+1] <= r_dv_ovfe[k];
            r_dv_d1[k+1]   <= r_dv_d1[k];
            r_dv_d1sq[k+1] <= r_dv_d1sq[k];
            r_xrem[k+1]    <= xge ? DX_W'(xt - {1'b0, dx}) : DX_W'(xt);
            r_xlo[k+1]     <= r_xlo[k] << 1;
            r_xq[k+1]      <= {r_xq[k][XQ_W-2:0], xge};
        end

        // The error divider is shorter; its result rides along afterwards.
        if (k < XE_QW) begin : g_estep
            logic [CFG_W:0] et;
            logic           ege;
            assign et  = {r_erem[k], r_elo[k][XE_QW-1]};
            assign ege = et >= {1'b0, b_eff};

            always_ff @(posedge i_clk) begin
                r_erem[k+1] <= ege ? CFG_W'(et - {1'b0, b_eff}) : CFG_W'(et);
                r_elo[k+1]  <= r_elo[k] << 1;
                r_eq[k+1]   <= {r_eq[k][XE_QW-2:0], ege};
            end
        end else begin : g_ehold
            always_ff @(posedge i_clk) begin
                r_erem[k+1] <= r_erem[k];
                r_elo[k+1]  <= r_elo[k];
                r_eq[k+1]   <= r_eq[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Post stage 1: saturate x, test whether the circles meet, and form
    // the products of the y error numerator and the x variance.
    // ------------------------------------------------------------------
    logic [XQ_W-1:0]   qx;
    logic [XE_QW-1:0]  qe;
    logic [RB-1:0]     ax;
    logic              nomeet;
    logic              xe_sat;
    logic [POSX_W-1:0] posx;

    assign qx     = r_xq[XQ_W];
    assign qe     = r_eq[XQ_W];
    assign ax     = qx[RB-1:0];
    assign nomeet = r_dv_ovfx[XQ_W] || (qx > XQ_W'(r_dv_d1[XQ_W]));
    assign xe_sat = r_dv_ovfe[XQ_W] || (qe[XE_QW-1:VAR_QW] != '0);

    always_comb begin
        if (r_dv_neg[XQ_W]) begin
            if (r_dv_ovfx[XQ_W] || (qx > POSX_MIN)) posx = POSX_MIN;
            else                                   posx = POSX_W'(-qx);
        end else begin
            if (r_dv_ovfx[XQ_W] || qx[XQ_W-1])     posx = POSX_MAX;
            else                                   posx = POSX_W'(qx);
        end
    end

    logic              r_p1_v;
    logic              r_p1_neg;
    logic              r_p1_nomeet;
    logic              r_p1_xbig;
    logic [POSX_W-1:0] r_p1_posx;
    logic [VAR_W-1:0]  r_p1_varx;
    logic [SQW-1:0]    r_p1_d1sq, r_p1_axsq;
    logic [XE2_W-1:0]  r_p1_xe2;
    logic [CR_W-1:0]   r_p1_cross;
    logic [DE_W-1:0]   r_p1_d1e;
    logic [31:0]       r_p1_esq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p1_v <= 1'b0;
        else          r_p1_v <= r_dv_v[XQ_W];
        r_p1_neg    <= r_dv_neg[XQ_W];
        r_p1_nomeet <= nomeet;
        r_p1_xbig   <= r_dv_ovfe[XQ_W];
        r_p1_posx   <= posx;
        r_p1_varx   <= xe_sat ? '1
                                : VAR_W'(qe[VAR_QW-1:0]) * VAR_W'(qe[VAR_QW-1:0]);
        r_p1_d1sq   <= r_dv_d1sq[XQ_W];
        r_p1_axsq   <= SQW'(ax) * SQW'(ax);
        r_p1_xe2    <= XE2_W'(qe) * XE2_W'(qe);
        r_p1_cross  <= CR_W'(ax) * CR_W'(qe);
        r_p1_d1e    <= DE_W'(r_dv_d1[XQ_W]) * DE_W'(r_err);
        r_p1_esq    <= 32'(r_err) * 32'(r_err);
    end

    // ------------------------------------------------------------------
    // Post stage 2: root argument and the two sides of the y error sum.
    // The cross term adds when x is nonnegative and subtracts otherwise.
    // ------------------------------------------------------------------
    logic              r_p2_v;
    logic              r_p2_nomeet;
    logic              r_p2_xbig;
    logic [POSX_W-1:0] r_p2_posx;
    logic [VAR_W-1:0]  r_p2_varx;
    logic [SQW-1:0]    r_p2_arg;
    logic [MAG_W-1:0]  r_p2_pos, r_p2_negt;
    logic [MAG_W-1:0]  cross2;

    assign cross2 = MAG_W'(r_p1_cross) << 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p2_v <= 1'b0;
        else          r_p2_v <= r_p1_v;
        r_p2_nomeet <= r_p1_nomeet;
        r_p2_xbig   <= r_p1_xbig;
        r_p2_posx   <= r_p1_posx;
        r_p2_varx   <= r_p1_varx;
        r_p2_arg    <= r_p1_d1sq - r_p1_axsq;
        r_p2_pos    <= (MAG_W'(r_p1_d1e) << 1) + MAG_W'(r_p1_esq) + MAG_W'(r_p1_xe2)
                       + (r_p1_neg ? '0 : cross2);
        r_p2_negt   <= r_p1_neg ? cross2 : '0;
    end

    // ------------------------------------------------------------------
    // Floor square root, two argument bits per stage. Stage 0 also takes
    // the magnitude of the y error numerator.
    // ------------------------------------------------------------------
    logic              r_sq_v      [0:RB];
    logic              r_sq_nomeet [0:RB];
    logic              r_sq_xbig   [0:RB];
    logic [POSX_W-1:0] r_sq_posx   [0:RB];
    logic [VAR_W-1:0]  r_sq_varx   [0:RB];
    logic [MAG_W-1:0]  r_sq_mag    [0:RB];
    logic [RB:0]       r_sq_rem    [0:RB];
    logic [RB-1:0]     r_sq_root   [0:RB];
    logic [SQW-1:0]    r_sq_a      [0:RB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sq_v[0] <= 1'b0;
        else          r_sq_v[0] <= r_p2_v;
        r_sq_nomeet[0] <= r_p2_nomeet;
        r_sq_xbig[0]   <= r_p2_xbig;
        r_sq_posx[0]   <= r_p2_posx;
        r_sq_varx[0]   <= r_p2_varx;
        r_sq_mag[0]    <= (r_p2_pos >= r_p2_negt) ? (r_p2_pos - r_p2_negt)
                                                  : (r_p2_negt - r_p2_pos);
        r_sq_rem[0]    <= '0;
        r_sq_root[0]   <= '0;
        r_sq_a[0]      <= r_p2_arg;
    end

    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        logic [RB+2:0] cur;
        logic [RB+1:0] trial;
        logic          sge;
        assign cur   = {r_sq_rem[k], r_sq_a[k][SQW-1:SQW-2]};
        assign trial = {r_sq_root[k], 2'b01};
        assign sge   = cur >= {1'b0, trial};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sq_v[k+1] <= 1'b0;
            else          r_sq_v[k+1] <= r_sq_v[k];
            r_sq_nomeet[k+1] <= r_sq_nomeet[k];
            r_sq_xbig[k+1]   <= r_sq_xbig[k];
            r_sq_posx[k+1]   <= r_sq_posx[k];
            r_sq_varx[k+1]   <= r_sq_varx[k];
            r_sq_mag[k+1]    <= r_sq_mag[k];
            r_sq_rem[k+1]    <= sge ? (RB+1)'(cur - {1'b0, trial}) : (RB+1)'(cur);
            r_sq_root[k+1]   <= {r_sq_root[k][RB-2:0], sge};
            r_sq_a[k+1]      <= r_sq_a[k] << 2;
        end
    end

    // ------------------------------------------------------------------
    // y error divider by 2y, one quotient bit per stage. A quotient of
    // 2^24 or more saturates its square, so only 24 bits are kept.
    // ------------------------------------------------------------------
    logic [RB-1:0]     yroot;
    logic [YDW-1:0]    d2_in;
    logic              ovfy_in;
    t_fix_status       st_in;
    logic [POSY_W-1:0] posy_in;

    assign yroot   = r_sq_root[RB];
    assign d2_in   = {yroot, 1'b0};
    assign ovfy_in = 64'(r_sq_mag[RB] >> VAR_QW) >= 64'(d2_in);

    always_comb begin
        if (r_sq_nomeet[RB])     st_in = ST_NOMEET;
        else if (yroot == '0)    st_in = ST_YZERO;
        else                     st_in = ST_VALID;
        if (r_sq_nomeet[RB])                posy_in = '0;
        else if (32'(yroot) > 32'hFFFF)     posy_in = '1;
        else                                posy_in = POSY_W'(yroot);
    end

    logic              r_yd_v    [0:VAR_QW];
    logic              r_yd_big  [0:VAR_QW];
    t_fix_status       r_yd_st   [0:VAR_QW];
    logic [POSX_W-1:0] r_yd_posx [0:VAR_QW];
    logic [POSY_W-1:0] r_yd_posy [0:VAR_QW];
    logic [VAR_W-1:0]  r_yd_varx [0:VAR_QW];
    logic [YDW-1:0]    r_yd_d    [0:VAR_QW];
    logic [YDW-1:0]    r_yrem    [0:VAR_QW];
    logic [VAR_QW-1:0] r_ylo     [0:VAR_QW];
    logic [VAR_QW-1:0] r_yq      [0:VAR_QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_yd_v[0] <= 1'b0;
        else          r_yd_v[0] <= r_sq_v[RB];
        r_yd_big[0]  <= r_sq_xbig[RB] || ovfy_in;
        r_yd_st[0]   <= st_in;
        r_yd_posx[0] <= r_sq_posx[RB];
        r_yd_posy[0] <= posy_in;
        r_yd_varx[0] <= r_sq_varx[RB];
        r_yd_d[0]    <= d2_in;
        r_yrem[0]    <= ovfy_in ? '0 : YDW'(r_sq_mag[RB] >> VAR_QW);
        r_ylo[0]     <= r_sq_mag[RB][VAR_QW-1:0];
        r_yq[0]      <= '0;
    end

    for (genvar k = 0; k < VAR_QW; k++) begin : g_ydiv
        logic [YDW:0] yt;
        logic         yge;
        assign yt  = {r_yrem[k], r_ylo[k][VAR_QW-1]};
        assign yge = yt >= {1'b0, r_yd_d[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_yd_v[k+1] <= 1'b0;
            else          r_yd_v[k+1] <= r_yd_v[k];
            r_yd_big[k+1]  <= r_yd_big[k];
            r_yd_st[k+1]   <= r_yd_st[k];
            r_yd_posx[k+1] <= r_yd_posx[k];
            r_yd_posy[k+1] <= r_yd_posy[k];
            r_yd_varx[k+1] <= r_yd_varx[k];
            r_yd_d[k+1]    <= r_yd_d[k];
            r_yrem[k+1]    <= yge ? YDW'(yt - {1'b0, r_yd_d[k]}) : YDW'(yt);
            r_ylo[k+1]     <= r_ylo[k] << 1;
            r_yq[k+1]      <= {r_yq[k][VAR_QW-2:0], yge};
        end
    end

    // ------------------------------------------------------------------
    // Output register: square the y error, saturate it when flagged, zero it unless the fix is valid.
    // ------------------------------------------------------------------
    logic              r_out_v;
    logic [POSX_W-1:0] r_out_posx;
    logic [POSY_W-1:0] r_out_posy;
    logic [VAR_W-1:0]  r_out_varx;
    logic [VAR_W-1:0]  r_out_vary;
    t_fix_status       r_out_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else          r_out_v <= r_yd_v[VAR_QW];
        r_out_posx <= r_yd_posx[VAR_QW];
        r_out_posy <= r_yd_posy[VAR_QW];
        r_out_varx <= r_yd_varx[VAR_QW];
        r_out_st   <= r_yd_st[VAR_QW];
        if (r_yd_st[VAR_QW] != ST_VALID) r_out_vary <= '0;
        else if (r_yd_big[VAR_QW])       r_out_vary <= '1;
        else r_out_vary <= VAR_W'(r_yq[VAR_QW]) * VAR_W'(r_yq[VAR_QW]);
    end

    assign o_done       = r_out_v;
    assign o_pos_x      = r_out_posx;
    assign o_pos_y      = r_out_posy;
    assign o_var_x      = r_out_varx;
    assign o_var_y      = r_out_vary;
    assign o_fix_status = r_out_st;

endmodule
